@@ rtl/core/kpsd_pkg.sv @@
package kpsd_pkg;

    localparam int unsigned ROWS          = 4;
    localparam int unsigned COLS          = 4;
    localparam int unsigned ROW_W         = 2;
    localparam int unsigned CODE_W        = 7;
    localparam int unsigned SETTLE_W      = 16;
    localparam int unsigned DEBOUNCE_W    = 20;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 20;

    localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = 16'd10;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd20000;
    localparam logic [CODE_W-1:0]     CODE_NONE      = 7'd0;
    localparam logic [ROW_W-1:0]      LAST_ROW       = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE   = 2'd0,
        REG_DEBOUNCE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [ROWS-1:0]   row_drive;
        logic              done;
        logic [CODE_W-1:0] code;
    } scan_res_t;

    typedef struct packed {
        logic              press_valid;
        logic [CODE_W-1:0] press_code;
        logic [CODE_W-1:0] stable_code;
    } deb_res_t;

    // Fixed layout: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
    function automatic logic [CODE_W-1:0] key_code(input logic [ROW_W-1:0] row,
                                                   input logic [1:0] col);
        logic [CODE_W-1:0] c;
        unique case ({row, col})
            4'h0: c = 7'h31;
            4'h1: c = 7'h32;
            4'h2: c = 7'h33;
            4'h3: c = 7'h41;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h42;
            4'h8: c = 7'h37;
            4'h9: c = 7'h38;
            4'hA: c = 7'h39;
            4'hB: c = 7'h43;
            4'hC: c = 7'h2A;
            4'hD: c = 7'h30;
            4'hE: c = 7'h23;
            default: c = 7'h44;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/kpsd_in_if.sv @@
interface kpsd_in_if;
    logic                      valid;
    logic                      ready;
    logic [kpsd_pkg::COLS-1:0] column_levels;

    modport source (output valid, output column_levels, input ready);
    modport sink   (input valid, input column_levels, output ready);
endinterface

@@ rtl/core/kpsd_out_if.sv @@
interface kpsd_out_if;
    logic                        valid;
    logic                        ready;
    logic [kpsd_pkg::ROWS-1:0]   row_drive;
    logic                        press_valid;
    logic [kpsd_pkg::CODE_W-1:0] press_code;
    logic [kpsd_pkg::CODE_W-1:0] stable_code;

    modport source (output valid, output row_drive, output press_valid,
                    output press_code, output stable_code, input ready);
    modport sink   (input valid, input row_drive, input press_valid,
                    input press_code, input stable_code, output ready);
endinterface

@@ rtl/core/kpsd_cfg_if.sv @@
interface kpsd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kpsd_pkg::CFG_IDX_W-1:0]  index;
    logic [kpsd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/kpsd_scan.sv @@
module kpsd_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [kpsd_pkg::SETTLE_W-1:0]   settle_ticks,
    input  logic [kpsd_pkg::COLS-1:0]       column_levels,
    output kpsd_pkg::scan_res_t             scan_res
);

    logic [kpsd_pkg::ROW_W-1:0]    row_reg;
    logic [kpsd_pkg::ROW_W-1:0]    row_next;
    logic [kpsd_pkg::SETTLE_W-1:0] settle_reg;
    logic [kpsd_pkg::SETTLE_W-1:0] settle_next;
    logic                          hit;
    logic [1:0]                    hit_col;

    // Lowest low column wins
    always_comb
    begin
        hit     = 1'b1;
        hit_col = 2'd0;
        priority if (!column_levels[0]) hit_col = 2'd0;
        else if (!column_levels[1])     hit_col = 2'd1;
        else if (!column_levels[2])     hit_col = 2'd2;
        else if (!column_levels[3])     hit_col = 2'd3;
        else                            hit = 1'b0;
    end

    always_comb
    begin
        scan_res.row_drive = ~(kpsd_pkg::ROWS'(1) << row_reg);
        scan_res.done      = 1'b0;
        scan_res.code      = kpsd_pkg::CODE_NONE;
        row_next           = row_reg;
        settle_next        = settle_reg;
        if (settle_reg < settle_ticks)
        begin
            settle_next = settle_reg + 1'b1;
        end
        else
        begin
            settle_next = '0;
            if (hit)
            begin
                scan_res.done = 1'b1;
                scan_res.code = kpsd_pkg::key_code(row_reg, hit_col);
                row_next      = '0;
            end
            else if (row_reg == kpsd_pkg::LAST_ROW)
            begin
                scan_res.done = 1'b1;
                row_next      = '0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            settle_reg <= '0;
        end
        else if (advance)
        begin
            row_reg    <= row_next;
            settle_reg <= settle_next;
        end
    end

endmodule

@@ rtl/core/kpsd_debounce.sv @@
module kpsd_debounce (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [kpsd_pkg::DEBOUNCE_W-1:0] debounce_ticks,
    input  kpsd_pkg::scan_res_t             scan_res,
    output kpsd_pkg::deb_res_t              deb_res
);

    logic [kpsd_pkg::CODE_W-1:0]     last_reg;
    logic [kpsd_pkg::CODE_W-1:0]     last_next;
    logic [kpsd_pkg::DEBOUNCE_W-1:0] count_reg;
    logic [kpsd_pkg::DEBOUNCE_W-1:0] count_next;
    logic [kpsd_pkg::CODE_W-1:0]     stable_reg;
    logic [kpsd_pkg::CODE_W-1:0]     stable_next;
    logic                            armed_reg;
    logic                            armed_next;

    always_comb
    begin
        last_next   = last_reg;
        count_next  = count_reg;
        stable_next = stable_reg;
        armed_next  = armed_reg;
        deb_res.press_valid = 1'b0;
        deb_res.press_code  = kpsd_pkg::CODE_NONE;

        if (scan_res.done && (scan_res.code != last_reg))
        begin
            last_next  = scan_res.code;
            count_next = '0;
        end
        else if (count_reg != '1)
        begin
            count_next = count_reg + 1'b1;
        end

        if (count_next >= debounce_ticks)
        begin
            stable_next = last_next;
            if (last_next == kpsd_pkg::CODE_NONE)
            begin
                armed_next = 1'b1;
            end
            else if (armed_reg)
            begin
                // report once, then wait for a stable release
                deb_res.press_valid = 1'b1;
                deb_res.press_code  = last_next;
                armed_next          = 1'b0;
            end
        end
        deb_res.stable_code = stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= kpsd_pkg::CODE_NONE;
            count_reg  <= '0;
            stable_reg <= kpsd_pkg::CODE_NONE;
            armed_reg  <= 1'b0;
        end
        else if (advance)
        begin
            last_reg   <= last_next;
            count_reg  <= count_next;
            stable_reg <= stable_next;
            armed_reg  <= armed_next;
        end
    end

endmodule

@@ rtl/core/keypad_scan_debounce_top.sv @@
// Channel  Dir  Payload                                          Role
// keys     in   column_levels[3:0]                               one time tick
// results  out  row_drive[3:0] press_valid press_code[6:0]
//               stable_code[6:0]                                 one result per tick
// cfg      in   index[1:0] data[19:0]                            register write
//
// One tick is accepted per cycle while results does not stall. Its result passes
// through the input register, then scan and debounce logic, into the result
// register.
// Reset is asynchronous, active low; registers return to settle 10, debounce 20000.
// A stall on results holds the result register, then the input register,
// then drops keys.ready. cfg.ready is always high.
module keypad_scan_debounce_top (
    input  logic      clk,
    input  logic      rst_n,
    kpsd_in_if.sink   keys,
    kpsd_out_if.source results,
    kpsd_cfg_if.sink  cfg
);

    logic [kpsd_pkg::SETTLE_W-1:0]   settle_reg;
    logic [kpsd_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic                            in_valid_reg;
    logic [kpsd_pkg::COLS-1:0]       cols_reg;
    logic                            out_valid_reg;
    logic [kpsd_pkg::ROWS-1:0]       drive_reg;
    kpsd_pkg::deb_res_t              deb_reg;
    logic                            advance;
    kpsd_pkg::scan_res_t             scan_res;
    kpsd_pkg::deb_res_t              deb_res;

    assign advance    = in_valid_reg && (!out_valid_reg || results.ready);
    assign keys.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= kpsd_pkg::SETTLE_RESET;
            debounce_reg <= kpsd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                kpsd_pkg::REG_SETTLE:   settle_reg   <= cfg.data[kpsd_pkg::SETTLE_W-1:0];
                kpsd_pkg::REG_DEBOUNCE: debounce_reg <= cfg.data[kpsd_pkg::DEBOUNCE_W-1:0];
                default:                ; // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (keys.valid && keys.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
            cols_reg <= keys.column_levels;
        if (advance)
        begin
            drive_reg <= scan_res.row_drive;
            deb_reg   <= deb_res;
        end
    end

    kpsd_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .settle_ticks  (settle_reg),
        .column_levels (cols_reg),
        .scan_res      (scan_res)
    );

    kpsd_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .debounce_ticks (debounce_reg),
        .scan_res       (scan_res),
        .deb_res        (deb_res)
    );

    assign results.valid       = out_valid_reg;
    assign results.row_drive   = drive_reg;
    assign results.press_valid = deb_reg.press_valid;
    assign results.press_code  = deb_reg.press_code;
    assign results.stable_code = deb_reg.stable_code;

endmodule
